// File: sv/grs_pkg.sv
// grs_pkg: shared types, codes and defaults for the grid reachability search
// used by the channel interface users and the top level; depends on nothing

package grs_pkg;

  localparam int COORD_W         = 6;
  localparam int RANGE_W         = 8;
  localparam int GRID_SIDE_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 4096;
  localparam int MAX_STEPS       = 255;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // cell word layout: {seen, passable}
  localparam int CELL_PASS = 0;
  localparam int CELL_SEEN = 1;

  localparam logic [2:0] DIR_E   = 3'd0;
  localparam logic [2:0] DIR_S   = 3'd1;
  localparam logic [2:0] DIR_W   = 3'd2;
  localparam logic [2:0] DIR_N   = 3'd3;
  localparam logic [2:0] DIR_END = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_passable;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [RANGE_W-1:0] search_range;
  } in_beat_t;

  typedef struct packed {
    logic               target_reachable;
    logic [RANGE_W-1:0] step_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LEVEL,
    ST_POP,
    ST_LOAD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/grs_chan_if.sv
// grs_chan_if: valid/ready channel carrying one beat of a payload type
// payload types come from grs_pkg at the point of instantiation

interface grs_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/grid_reachability_search.sv
// grid_reachability_search: depth-limited breadth-first flood fill on a square grid
// depends on grs_pkg, grs_chan_if and grs_ram
//
// Usage: in_ch takes one beat per item. A write beat (operation = write) sets the
// passable bit of one cell as it is taken and gives no result. A query beat floods
// from the origin and gives exactly one out_ch beat (target_reachable, step_count).
// A query with range zero, or with origin equal to target, answers straight from
// the done state. Any other query first sweeps the cell ram to clear the seen
// bits and mark the origin, one ram entry a cycle, then expands each queued cell
// in turn (queue read, load, four neighbour read/check slots on the cell ram, one
// drain slot), with a level step and an end-of-level pop check for each level.
// The single read port of the cell ram sets the pace of the flood.
// Items are taken one at a time; in_ch.ready is high only while idle.
// After reset the block runs a clearing pass over the whole cell ram that
// makes every cell impassable; in_ch.ready stays low meanwhile.
// Results sit in an output register: while out_ch stalls the block keeps taking
// items, and a later query result waits until the register is free.

module grid_reachability_search
  import grs_pkg::*;
#(
  parameter int GRID_SIDE   = GRID_SIDE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  grs_chan_if.sink   in_ch,
  grs_chan_if.source out_ch
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = (COORD_W > $clog2(GRID_SIDE)) ? COORD_W : $clog2(GRID_SIDE);
  localparam int XW    = CW + 1;
  localparam int QAW   = $clog2(QUEUE_DEPTH);
  localparam int QCW   = QAW + 1;
  localparam int QW    = 2 * CW;

  localparam logic [AW:0]   CELL_END = (AW + 1)'(CELLS);
  localparam logic [QCW-1:0] Q_END   = QCW'(QUEUE_DEPTH);
  localparam logic [XW-1:0] SIDE_X   = XW'(GRID_SIDE);

  function automatic logic [AW-1:0] idx_of(logic [XW-1:0] x, logic [XW-1:0] y);
    idx_of = AW'(32'(y) * 32'(GRID_SIDE) + 32'(x));
  endfunction

  in_beat_t  in_beat;
  out_beat_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_load;

  state_t state_r, state_nxt;
  logic [AW:0]          cnt_r, cnt_nxt;
  logic [AW:0]          sweep_prev;
  logic [COORD_W-1:0]   ox_r, ox_nxt, oy_r, oy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic [RANGE_W-1:0]   rng_r, rng_nxt, level_r, level_nxt;
  logic [RANGE_W-1:0]   rng_in;
  logic [QCW-1:0]       head_r, head_nxt, tail_r, tail_nxt, lend_r, lend_nxt;
  logic                 added_r, added_nxt;
  logic [CW-1:0]        cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0]           dir_r, dir_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]        pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [RANGE_W-1:0]   res_step_r, res_step_nxt;

  logic [XW-1:0]  org_x, org_y, wr_x, wr_y, cxe, cye, nb_x, nb_y;
  logic           org_in, wr_in, nb_dir_ok, nb_ok;
  logic [AW-1:0]  org_idx, nb_idx;

  logic           cell_we;
  logic [AW-1:0]  cell_waddr, cell_raddr;
  logic [1:0]     cell_wdata, cell_rd;
  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [QW-1:0]  q_wdata, q_rd;

  assign in_beat        = in_ch.data;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.data    = out_data_r;

  assign rng_in = (32'(in_beat.search_range) > MAX_STEPS) ? RANGE_W'(MAX_STEPS)
                                                          : in_beat.search_range;

  assign org_x   = XW'(ox_r);
  assign org_y   = XW'(oy_r);
  assign org_in  = (org_x < SIDE_X) && (org_y < SIDE_X);
  assign org_idx = idx_of(org_x, org_y);
  assign wr_x    = XW'(in_beat.cell_x);
  assign wr_y    = XW'(in_beat.cell_y);
  assign wr_in   = (wr_x < SIDE_X) && (wr_y < SIDE_X);
  assign sweep_prev = cnt_r - 1'b1;

  // neighbour of the current cell in direction dir_r
  assign cxe = XW'(cx_r);
  assign cye = XW'(cy_r);
  always_comb begin
    nb_x      = cxe;
    nb_y      = cye;
    nb_dir_ok = 1'b0;
    case (dir_r)
      DIR_E: begin
        nb_x      = cxe + 1'b1;
        nb_dir_ok = 1'b1;
      end
      DIR_S: begin
        nb_y      = cye + 1'b1;
        nb_dir_ok = 1'b1;
      end
      DIR_W: begin
        nb_x      = cxe - 1'b1;
        nb_dir_ok = (cx_r != '0);
      end
      DIR_N: begin
        nb_y      = cye - 1'b1;
        nb_dir_ok = (cy_r != '0);
      end
      default: nb_dir_ok = 1'b0;
    endcase
  end
  assign nb_ok  = nb_dir_ok && (nb_x < SIDE_X) && (nb_y < SIDE_X);
  assign nb_idx = idx_of(nb_x, nb_y);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    tx_nxt       = tx_r;
    ty_nxt       = ty_r;
    rng_nxt      = rng_r;
    level_nxt    = level_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    lend_nxt     = lend_r;
    added_nxt    = added_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    dir_nxt      = dir_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    res_hit_nxt  = res_hit_r;
    res_step_nxt = res_step_r;
    out_load     = 1'b0;
    cell_we      = 1'b0;
    cell_waddr   = pend_idx_r;
    cell_wdata   = 2'b11;
    cell_raddr   = nb_idx;
    q_we         = 1'b0;
    q_waddr      = tail_r[QAW-1:0];
    q_wdata      = {pend_y_r, pend_x_r};

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        // read cnt, write cnt-1: init zeroes it, clear sets seen only at origin
        cell_raddr = cnt_r[AW-1:0];
        if (cnt_r != '0) begin
          cell_we    = 1'b1;
          cell_waddr = sweep_prev[AW-1:0];
          if (state_r == ST_INIT) begin
            cell_wdata = 2'b00;
          end else begin
            cell_wdata = {org_in && (sweep_prev[AW-1:0] == org_idx), cell_rd[CELL_PASS]};
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CELL_END) begin
          if (state_r == ST_INIT) begin
            state_nxt = ST_IDLE;
          end else begin
            head_nxt  = '0;
            tail_nxt  = QCW'(1);
            level_nxt = RANGE_W'(1);
            state_nxt = ST_LEVEL;
          end
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_beat.operation == OP_WRITE) begin
            cell_we    = wr_in;
            cell_waddr = idx_of(wr_x, wr_y);
            cell_wdata = {1'b0, in_beat.cell_passable};
          end else begin
            ox_nxt  = in_beat.origin_x;
            oy_nxt  = in_beat.origin_y;
            tx_nxt  = in_beat.target_x;
            ty_nxt  = in_beat.target_y;
            rng_nxt = rng_in;
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = {CW'(in_beat.origin_y), CW'(in_beat.origin_x)};
            if (rng_in == '0) begin
              res_hit_nxt  = 1'b0;
              res_step_nxt = '0;
              state_nxt    = ST_DONE;
            end else if (in_beat.origin_x == in_beat.target_x &&
                         in_beat.origin_y == in_beat.target_y) begin
              res_hit_nxt  = 1'b1;
              res_step_nxt = '0;
              state_nxt    = ST_DONE;
            end else begin
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
          end
        end
      end
      ST_LEVEL: begin
        lend_nxt  = tail_r;
        added_nxt = 1'b0;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (head_r < lend_r) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_LOAD;
        end else if (!added_r || level_r == rng_r) begin
          res_hit_nxt  = 1'b0;
          res_step_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          level_nxt = level_r + 1'b1;
          state_nxt = ST_LEVEL;
        end
      end
      ST_LOAD: begin
        cx_nxt     = q_rd[CW-1:0];
        cy_nxt     = q_rd[QW-1:CW];
        dir_nxt    = DIR_E;
        pend_v_nxt = 1'b0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        // check the neighbour read last cycle while reading the next one
        if (pend_v_r && cell_rd[CELL_PASS] && !cell_rd[CELL_SEEN]) begin
          cell_we   = 1'b1;
          added_nxt = 1'b1;
          if (pend_x_r == CW'(tx_r) && pend_y_r == CW'(ty_r)) begin
            res_hit_nxt  = 1'b1;
            res_step_nxt = level_r;
            state_nxt    = ST_DONE;
          end else if (tail_r < Q_END) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
        pend_v_nxt   = nb_ok;
        pend_idx_nxt = nb_idx;
        pend_x_nxt   = nb_x[CW-1:0];
        pend_y_nxt   = nb_y[CW-1:0];
        dir_nxt      = dir_r + 1'b1;
        if (dir_r == DIR_END && state_nxt == ST_SCAN) begin
          state_nxt = ST_POP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{target_reachable: res_hit_r, step_count: res_step_r};
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    rng_r      <= rng_nxt;
    level_r    <= level_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    lend_r     <= lend_nxt;
    added_r    <= added_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    dir_r      <= dir_nxt;
    pend_v_r   <= pend_v_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_y_r   <= pend_y_nxt;
    res_hit_r  <= res_hit_nxt;
    res_step_r <= res_step_nxt;
  end

  grs_ram #(
    .WIDTH (2),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_addr (cell_raddr),
    .rd_data (cell_rd)
  );

  grs_ram #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_addr (head_r[QAW-1:0]),
    .rd_data (q_rd)
  );

`ifndef ASSERT_OFF
  a_scan_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cell_we) |-> (cell_waddr != cell_raddr))
    else $error("neighbour check writes the entry being read");

  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (head_r <= tail_r))
    else $error("queue head passed tail");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result beat raised outside the done state");
`endif

endmodule

// File: sv/grs_ram.sv
// grs_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module grs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: verif/grid_reachability_search_test.sv
// grid_reachability_search_test: self-checking bench for the grid reachability search
// predicts each query answer with its own flood over a copy of the cell map
// depends on grs_pkg, grs_chan_if and grid_reachability_search

module grid_reachability_search_test
  import grs_pkg::*;
();

  localparam int CELLS      = GRID_SIDE_DEF * GRID_SIDE_DEF;
  localparam int PATH_ROWS  = 3;
  localparam int ROW_CELLS  = 12;
  localparam int PATH_LEN   = PATH_ROWS * ROW_CELLS + PATH_ROWS - 1;
  localparam int DRAIN_WAIT = 40;

  logic clk = 1'b0;
  logic rst_n;

  grs_chan_if #(.data_t(in_beat_t))  in_ch ();
  grs_chan_if #(.data_t(out_beat_t)) out_ch ();

  grid_reachability_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  bit        passable_cells [CELLS];
  bit        seen_cells [CELLS];
  int        frontier [QUEUE_DEPTH_DEF];
  out_beat_t pending_answers [$];

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int write_count;
  int query_count;
  int checked_count;

  // breadth-first flood over the local cell map, one level at a time
  function automatic out_beat_t flood_answer(input in_beat_t b);
    int        dx [4] = '{1, 0, -1, 0};
    int        dy [4] = '{0, 1, 0, -1};
    int        head, tail, level_end, lvl, limit;
    int        cx, cy, nx, ny, idx, d;
    bit        grew;
    out_beat_t r;
    r = '0;
    limit = int'(b.search_range);
    if (limit > MAX_STEPS) limit = MAX_STEPS;
    if (limit == 0) return r;
    if (b.origin_x == b.target_x && b.origin_y == b.target_y) begin
      r.target_reachable = 1'b1;
      return r;
    end
    foreach (seen_cells[i]) seen_cells[i] = 1'b0;
    idx = b.origin_y * GRID_SIDE_DEF + b.origin_x;
    seen_cells[idx] = 1'b1;
    frontier[0] = idx;
    head = 0;
    tail = 1;
    for (lvl = 1; lvl <= limit; lvl++) begin
      level_end = tail;
      grew = 1'b0;
      while (head < level_end) begin
        cx = frontier[head] % GRID_SIDE_DEF;
        cy = frontier[head] / GRID_SIDE_DEF;
        head++;
        for (d = 0; d < 4; d++) begin
          nx = cx + dx[d];
          ny = cy + dy[d];
          if (nx < 0 || ny < 0 || nx >= GRID_SIDE_DEF || ny >= GRID_SIDE_DEF) continue;
          idx = ny * GRID_SIDE_DEF + nx;
          if (!passable_cells[idx] || seen_cells[idx]) continue;
          seen_cells[idx] = 1'b1;
          grew = 1'b1;
          if (nx == b.target_x && ny == b.target_y) begin
            r.target_reachable = 1'b1;
            r.step_count = lvl[RANGE_W-1:0];
            return r;
          end
          if (tail < QUEUE_DEPTH_DEF) begin
            frontier[tail] = idx;
            tail++;
          end
        end
      end
      if (!grew) break;
    end
    return r;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.operation     = 1'($urandom_range(1));
    b.cell_x        = COORD_W'($urandom_range(63));
    b.cell_y        = COORD_W'($urandom_range(63));
    b.cell_passable = 1'($urandom_range(1));
    b.origin_x      = COORD_W'($urandom_range(63));
    b.origin_y      = COORD_W'($urandom_range(63));
    b.target_x      = COORD_W'($urandom_range(63));
    b.target_y      = COORD_W'($urandom_range(63));
    b.search_range  = RANGE_W'($urandom_range(255));
    return b;
  endfunction

  function automatic in_beat_t write_beat(input int x, input int y, input bit p);
    in_beat_t b;
    b = random_beat();
    b.operation     = OP_WRITE;
    b.cell_x        = COORD_W'(x);
    b.cell_y        = COORD_W'(y);
    b.cell_passable = p;
    return b;
  endfunction

  function automatic in_beat_t query_beat(input int ox, input int oy, input int tx,
                                          input int ty, input int rng);
    in_beat_t b;
    b = random_beat();
    b.operation    = OP_QUERY;
    b.origin_x     = COORD_W'(ox);
    b.origin_y     = COORD_W'(oy);
    b.target_x     = COORD_W'(tx);
    b.target_y     = COORD_W'(ty);
    b.search_range = RANGE_W'(rng);
    return b;
  endfunction

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        send_idle_pct = 37;
        stall_pct     = 52;
      end
      1: begin
        send_idle_pct = 52;
        stall_pct     = 37;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  task automatic send_beat(input in_beat_t b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (b.operation == OP_WRITE) begin
      if (b.cell_x < GRID_SIDE_DEF && b.cell_y < GRID_SIDE_DEF)
        passable_cells[b.cell_y * GRID_SIDE_DEF + b.cell_x] = b.cell_passable;
      write_count++;
    end else begin
      pending_answers = {pending_answers, flood_answer(b)};
      query_count++;
    end
  endtask

  // result side: random stalls, compare each beat with the oldest answer
  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result beat: target_reachable %0d step_count %0d",
               out_ch.data.target_reachable, out_ch.data.step_count);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        checked_count++;
        if (out_ch.data.target_reachable !== want.target_reachable) begin
          $error("target_reachable: expected %0d, got %0d",
                 want.target_reachable, out_ch.data.target_reachable);
          error_count++;
        end
        if (out_ch.data.step_count !== want.step_count) begin
          $error("step_count: expected %0d, got %0d", want.step_count, out_ch.data.step_count);
          error_count++;
        end
      end
    end
  end

  task automatic test_corner_cases();
    set_idling(0);
    send_beat(query_beat(5, 5, 5, 5, 0));
    send_beat(query_beat(5, 5, 5, 5, 1));
    send_beat(query_beat(0, 0, 63, 63, 255));
    send_beat(write_beat(63, 63, 1'b1));
    send_beat(write_beat(62, 63, 1'b1));
    send_beat(query_beat(63, 63, 62, 63, 1));
    send_beat(query_beat(61, 63, 62, 63, 1));
    send_beat(query_beat(63, 63, 62, 63, 0));
    send_beat(write_beat(0, 0, 1'b1));
    send_beat(write_beat(1, 0, 1'b1));
    send_beat(write_beat(2, 0, 1'b1));
    send_beat(query_beat(0, 0, 2, 0, 1));
    send_beat(query_beat(0, 0, 2, 0, 2));
    send_beat(query_beat(3, 0, 0, 0, 128));
    send_beat(write_beat(1, 0, 1'b0));
    send_beat(query_beat(0, 0, 2, 0, 255));
    send_beat(query_beat(63, 62, 63, 63, 255));
    send_beat(write_beat(63, 0, 1'b1));
    send_beat(query_beat(62, 0, 63, 0, 1));
    send_beat(query_beat(0, 63, 0, 62, 255));
    send_beat(write_beat(0, 62, 1'b1));
    send_beat(query_beat(0, 63, 0, 62, 127));
  endtask

  // serpentine corridor: distance along it equals index
  task automatic test_long_corridor();
    int px [PATH_LEN];
    int py [PATH_LEN];
    int n, r, k, y;
    set_idling(1);
    n = 0;
    for (r = 0; r < PATH_ROWS; r++) begin
      y = 20 + 2 * r;
      for (k = 0; k < ROW_CELLS; k++) begin
        px[n] = (r % 2 == 0) ? 2 + k : 1 + ROW_CELLS - k;
        py[n] = y;
        n++;
      end
      if (r < PATH_ROWS - 1) begin
        px[n] = px[n-1];
        py[n] = y + 1;
        n++;
      end
    end
    for (k = 0; k < PATH_LEN; k++) send_beat(write_beat(px[k], py[k], 1'b1));
    send_beat(query_beat(px[0], py[0], px[37], py[37], 255));
    send_beat(query_beat(px[0], py[0], px[37], py[37], 36));
    send_beat(query_beat(px[0], py[0], px[37], py[37], 37));
    send_beat(query_beat(px[0], py[0], px[20], py[20], 200));
    send_beat(query_beat(px[10], py[10], px[37], py[37], 27));
    send_beat(query_beat(px[37], py[37], px[5], py[5], 255));
    send_beat(write_beat(px[18], py[18], 1'b0));
    send_beat(query_beat(px[0], py[0], px[30], py[30], 255));
    send_beat(query_beat(px[30], py[30], px[0], py[0], 255));
  endtask

  // small random rooms: mostly writes and queries inside a window that moves now and then, some noise
  task automatic test_random_rooms(input int phase, input int budget);
    int bx, by, w, h, pick, sent, rng;
    set_idling(phase);
    w  = $urandom_range(10, 2);
    h  = $urandom_range(6, 2);
    bx = $urandom_range(GRID_SIDE_DEF - w);
    by = $urandom_range(GRID_SIDE_DEF - h);
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        w  = $urandom_range(10, 2);
        h  = $urandom_range(6, 2);
        bx = $urandom_range(GRID_SIDE_DEF - w);
        by = $urandom_range(GRID_SIDE_DEF - h);
      end else begin
        if (pick < 55) begin
          send_beat(write_beat(bx + $urandom_range(w - 1), by + $urandom_range(h - 1),
                               $urandom_range(99) < 80));
        end else if (pick < 88) begin
          rng = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(w + h + 2);
          send_beat(query_beat(bx + $urandom_range(w - 1), by + $urandom_range(h - 1),
                               bx + $urandom_range(w - 1), by + $urandom_range(h - 1), rng));
        end else begin
          send_beat(random_beat());
        end
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    error_count   = 0;
    write_count   = 0;
    query_count   = 0;
    checked_count = 0;
    set_idling(0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_long_corridor();
    test_random_rooms(0, 12);
    test_random_rooms(1, 11);
    test_random_rooms(2, 11);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("run covered %0d cell writes and %0d queries, %0d answers checked",
             write_count, query_count, checked_count);
    $display("range edges, blocked paths, a winding corridor and random rooms");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #72_000_000;
    $display("timeout waiting for the search to finish");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
